FILE: rtl/tdpr_pkg.sv
// Shared types, constants and checksum helper for the TCP destination port rewriter.
// No dependencies; used by tdpr_front, tdpr_queue, tdpr_back and the top level.
package tdpr_pkg;

  // Configuration register indexes
  localparam logic REG_MATCH_PORT   = 1'b0;
  localparam logic REG_REWRITE_PORT = 1'b1;

  localparam logic [15:0] MATCH_PORT_RESET   = 16'd5000;
  localparam logic [15:0] REWRITE_PORT_RESET = 16'd15003;

  // Byte positions in the frame, at which header fields are captured
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_IHL      = 7'd14;
  localparam logic [6:0] POS_PROTO    = 7'd23;
  localparam logic [6:0] POS_DPORT_LO = 7'd37;
  localparam logic [6:0] POS_DOFF     = 7'd46;
  localparam logic [6:0] POS_CSUM_LO  = 7'd51;
  localparam logic [6:0] COUNT_MAX    = 7'd127;

  // Minimum lengths
  localparam logic [7:0] LEN_ETH  = 8'd14;
  localparam logic [7:0] LEN_IP   = 8'd34;
  localparam logic [7:0] LEN_TCP  = 8'd54;
  localparam logic [3:0] DOFF_MIN = 4'd5;

  localparam logic [7:0] ETYPE_HI  = 8'h08;
  localparam logic [7:0] ETYPE_LO  = 8'h00;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  // Work handed from front to back: up to three output beats.
  // The last flag (and verdict/rewritten) apply to the final beat only.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic            verdict;
    logic            rewritten;
    logic [2:0][7:0] bytes;
  } entry_t;

  // RFC 1624 incremental update: HC' = ~(~HC + ~m + m'), end-around carry
  function automatic logic [15:0] csum_update(input logic [15:0] hc,
                                              input logic [15:0] m,
                                              input logic [15:0] mn);
    logic [17:0] s;
    logic [16:0] f1;
    logic [15:0] f2;
    s  = {2'b00, ~hc} + {2'b00, ~m} + {2'b00, mn};
    f1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

endpackage

FILE: rtl/tdpr_front.sv
// Front end: accepts frame bytes, keeps the two-byte hold, parses headers,
// rewrites port and checksum, and pushes output work into the queue. Uses tdpr_pkg.
module tdpr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [15:0]           cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tlast,
  input  logic                  q_full,
  output logic                  push,
  output tdpr_pkg::entry_t      push_entry
);

  logic [15:0] match_port;
  logic [15:0] rewrite_port;

  logic [6:0]  count;
  logic [7:0]  dl0, dl1;
  logic [1:0]  filled;
  logic        is_ipv4, is_tcp, matched;
  logic [3:0]  hdr_words, doff_words;
  logic [15:0] old_port;

  logic [6:0]  count_next;
  logic [7:0]  dl0_next, dl1_next;
  logic [7:0]  s0, s1;
  logic [1:0]  filled_next;
  logic        is_ipv4_next, is_tcp_next, matched_next;
  logic [3:0]  hdr_words_next, doff_words_next;
  logic [15:0] old_port_next;
  logic [15:0] csum_new;
  logic        accept, shift, drop;
  logic [7:0]  len;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign shift    = (filled == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_port   <= tdpr_pkg::MATCH_PORT_RESET;
      rewrite_port <= tdpr_pkg::REWRITE_PORT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tdpr_pkg::REG_MATCH_PORT:   match_port   <= cfg_wdata;
        tdpr_pkg::REG_REWRITE_PORT: rewrite_port <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign csum_new = tdpr_pkg::csum_update({s0, s1}, old_port, rewrite_port);

  always_comb begin
    count_next  = (count == tdpr_pkg::COUNT_MAX) ? count : count + 7'd1;
    filled_next = shift ? filled : filled + 2'd1;
    // hold contents after taking the new byte
    s0 = shift ? dl1 : ((filled == 2'd0) ? s_tdata : dl0);
    s1 = (shift || filled == 2'd1) ? s_tdata : dl1;

    dl0_next        = s0;
    dl1_next        = s1;
    is_ipv4_next    = is_ipv4;
    is_tcp_next     = is_tcp;
    hdr_words_next  = hdr_words;
    doff_words_next = doff_words;
    old_port_next   = old_port;
    matched_next    = matched;

    unique case (count)
      tdpr_pkg::POS_ETYPE_LO:
        is_ipv4_next = (s0 == tdpr_pkg::ETYPE_HI) && (s1 == tdpr_pkg::ETYPE_LO);
      tdpr_pkg::POS_IHL:
        hdr_words_next = s_tdata[3:0];
      tdpr_pkg::POS_PROTO:
        is_tcp_next = (s_tdata == tdpr_pkg::PROTO_TCP);
      tdpr_pkg::POS_DPORT_LO: begin
        old_port_next = {s0, s1};
        matched_next  = is_ipv4 && is_tcp && ({s0, s1} == match_port);
        if (matched_next) begin
          dl0_next = rewrite_port[15:8];
          dl1_next = rewrite_port[7:0];
        end
      end
      tdpr_pkg::POS_DOFF:
        doff_words_next = s_tdata[7:4];
      tdpr_pkg::POS_CSUM_LO: begin
        if (matched) begin
          dl0_next = csum_new[15:8];
          dl1_next = csum_new[7:0];
        end
      end
      default: ;
    endcase
  end

  // Verdict on the length including this beat
  always_comb begin
    len = {1'b0, count_next};
    if (len < tdpr_pkg::LEN_ETH)                                  drop = 1'b1;
    else if (!is_ipv4_next)                                       drop = 1'b0;
    else if (len < tdpr_pkg::LEN_IP)                              drop = 1'b1;
    else if (!is_tcp_next)                                        drop = 1'b0;
    else if (len < tdpr_pkg::LEN_TCP)                             drop = 1'b1;
    else if (!matched_next)                                       drop = 1'b0;
    else if (len < tdpr_pkg::LEN_ETH + {2'b00, hdr_words_next, 2'b00})   drop = 1'b1;
    else if (len < tdpr_pkg::LEN_IP + {2'b00, doff_words_next, 2'b00})   drop = 1'b1;
    else if (doff_words_next < tdpr_pkg::DOFF_MIN)                drop = 1'b1;
    else                                                          drop = 1'b0;
  end

  always_comb begin
    push_entry.last      = s_tlast;
    push_entry.verdict   = s_tlast && drop;
    push_entry.rewritten = s_tlast && matched_next && !drop;
    push_entry.cnt       = 2'd1;
    push_entry.bytes     = {8'd0, 8'd0, dl0};
    if (s_tlast) begin
      unique case (filled)
        2'd2:    begin
          push_entry.cnt   = 2'd3;
          push_entry.bytes = {dl1_next, dl0_next, dl0};
        end
        2'd1:    begin
          push_entry.cnt   = 2'd2;
          push_entry.bytes = {8'd0, dl1_next, dl0_next};
        end
        default: begin
          push_entry.cnt   = 2'd1;
          push_entry.bytes = {8'd0, 8'd0, dl0_next};
        end
      endcase
    end
  end

  assign push = accept && (shift || s_tlast);

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      count      <= '0;
      dl0        <= '0;
      dl1        <= '0;
      filled     <= '0;
      is_ipv4    <= 1'b0;
      is_tcp     <= 1'b0;
      hdr_words  <= '0;
      doff_words <= '0;
      old_port   <= '0;
      matched    <= 1'b0;
    end else if (accept) begin
      count      <= count_next;
      dl0        <= dl0_next;
      dl1        <= dl1_next;
      filled     <= filled_next;
      is_ipv4    <= is_ipv4_next;
      is_tcp     <= is_tcp_next;
      hdr_words  <= hdr_words_next;
      doff_words <= doff_words_next;
      old_port   <= old_port_next;
      matched    <= matched_next;
    end
  end

endmodule

FILE: rtl/tdpr_queue.sv
// Small register FIFO of output work between front and back.
// Uses tdpr_pkg::entry_t.
module tdpr_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tdpr_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output tdpr_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  tdpr_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] used;
  logic          do_push, do_pop;

  assign full       = (used == CW'(DEPTH));
  assign head_valid = (used != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      used <= used + CW'(1);
      else if (do_pop && !do_push) used <= used - CW'(1);
    end
  end

endmodule

FILE: rtl/tdpr_back.sv
// Back end: takes work entries from the queue and sends their bytes
// through a registered master stream, one beat per cycle while m_tready allows. Uses tdpr_pkg.
module tdpr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  tdpr_pkg::entry_t head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic [1:0]       m_tuser
);

  tdpr_pkg::entry_t cur;
  logic             cur_valid;
  logic [1:0]       pos;
  logic             load, cur_done;

  assign load     = cur_valid && (!m_tvalid || m_tready);
  assign cur_done = (pos == cur.cnt - 2'd1);
  assign pop      = head_valid && (!cur_valid || (load && cur_done));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      pos       <= '0;
    end else if (load && cur_done) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur.bytes[pos];
      m_tlast <= cur.last && cur_done;
      m_tuser <= {cur.rewritten && cur_done, cur.verdict && cur_done};
    end
  end

endmodule

FILE: rtl/tcp_dest_port_rewriter.sv
// Top level of the TCP destination port rewriter.
// Depends on tdpr_pkg, tdpr_front, tdpr_queue and tdpr_back.
//
// Frame bytes enter on the s_ stream (one byte per beat, s_tlast on the final
// byte) and leave on the m_ stream after a two-byte hold. In IPv4/TCP frames a
// destination port equal to match_port becomes the rewrite port and the TCP
// checksum is patched incrementally. The final output beat of a frame carries the
// verdict (m_tuser[0]: 1 = drop) and the rewritten flag (m_tuser[1]).
// Throughput: one byte per cycle in and out, unless a full queue or a low m_tready
// holds the flow. The final input beat of a frame releases up to three output
// beats; the work queue absorbs the extra beats, so back-to-back frames keep full
// rate on the input except when the queue fills. With the back end idle, an
// output beat released by an accepted input beat is written into a queue slot,
// then the work register, then the output register before reaching the m_ ports.
// The queue holds QUEUE_DEPTH entries; s_tready drops only when it is full,
// i.e. when the receiver stalls m_tready long enough.
// Configuration: cfg_we with cfg_addr 0 = match_port, 1 = rewrite port.
// Reset (rst, synchronous) empties the queue and output, clears the frame
// state and restores match_port = 5000, rewrite port = 15003.
module tcp_dest_port_rewriter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic [1:0]  m_tuser    // [0] verdict, [1] rewritten
);

  tdpr_pkg::entry_t push_entry, head;
  logic             push, q_full, pop, head_valid;

  tdpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tdpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tdpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
